### rtl/ccgs_pkg.sv
package ccgs_pkg;

    // Default build limits.
    localparam int MAX_DEGREE_DEF  = 16;
    localparam int MAX_RESULTS_DEF = 64;

    // Field widths of the request and the result.
    localparam int LEN_W    = 16;
    localparam int OP_W     = 2;
    localparam int WEIGHT_W = 7;
    localparam int STATUS_W = 2;
    localparam int GEN_W    = 64;

    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [OP_W-1:0]     t_op;

    // Result status codes.
    localparam t_status ST_FOUND   = 2'd0;
    localparam t_status ST_NONE    = 2'd1;
    localparam t_status ST_INVALID = 2'd2;

    // Search modes.
    localparam t_op OP_LOWEST  = 2'd0;
    localparam t_op OP_HIGHEST = 2'd1;
    localparam t_op OP_ALL     = 2'd2;
    localparam t_op OP_WEIGHT  = 2'd3;

endpackage

### rtl/ccgs_ram.sv
module ccgs_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/cyclic_code_generator_search.sv
// An invalid request gives its single result in the cycle after acceptance. A valid
// request tests each candidate through the single shift/XOR reduction step, with a weight
// check first in weight mode; up to 2^(m-1) candidates are tested, then each divisor found
// is read from the registered result memory and delivered in turn.
// Throughput: one request at a time; busy is high from acceptance to the last result.
// Reset: synchronous, active low; the sequencer returns to idle, memory is not cleared.
// Results cannot be stalled: each is shown for exactly one cycle with o_result_valid.
module cyclic_code_generator_search #(
    parameter int MAX_DEGREE  = ccgs_pkg::MAX_DEGREE_DEF,
    parameter int MAX_RESULTS = ccgs_pkg::MAX_RESULTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ccgs_pkg::LEN_W-1:0]        i_block_length,
    input  logic [ccgs_pkg::LEN_W-1:0]        i_message_length,
    input  logic [ccgs_pkg::OP_W-1:0]         i_op,
    input  logic [ccgs_pkg::WEIGHT_W-1:0]     i_wanted_weight,
    output logic                              o_result_valid,
    output logic [ccgs_pkg::STATUS_W-1:0]     o_status,
    output logic [ccgs_pkg::GEN_W-1:0]        o_generator,
    output logic                              o_last_result,
    output logic                              o_truncated
);

    // Polynomials of degree up to MAX_DEGREE need MAX_DEGREE + 1 coefficient bits.
    localparam int DW = MAX_DEGREE + 1;
    // Width of a degree or a coefficient index.
    localparam int MW = $clog2(MAX_DEGREE + 1);
    // Result memory address and result count widths.
    localparam int AW = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
    localparam int CW = $clog2(MAX_RESULTS + 1);
    localparam int LW = ccgs_pkg::LEN_W;
    localparam int WW = ccgs_pkg::WEIGHT_W;
    // Exponent bit index: the exponent is LEN_W bits wide.
    localparam int BW = $clog2(ccgs_pkg::LEN_W);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TEST   = 4'd1;
    localparam logic [3:0] S_WEIGHT = 4'd2;
    localparam logic [3:0] S_POW    = 4'd3;
    localparam logic [3:0] S_SQ     = 4'd4;
    localparam logic [3:0] S_MX     = 4'd5;
    localparam logic [3:0] S_CHECK  = 4'd6;
    localparam logic [3:0] S_NEXT   = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;
    localparam logic [3:0] S_RD     = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;
    localparam logic [3:0] S_STAT   = 4'd11;

    // Multiply by x modulo g, with r held below degree m.
    function automatic logic [DW-1:0] f_times_x(input logic [DW-1:0] r,
                                                input logic [DW-1:0] g,
                                                input logic [DW-1:0] top);
        logic [DW-1:0] s;
        s = r << 1;
        if ((s & top) != '0) begin
            s = s ^ g;
        end
        return s;
    endfunction

    logic [3:0]              r_state, n_state;
    logic [LW-1:0]           r_n, n_n;
    logic [MW-1:0]           r_m, n_m;
    ccgs_pkg::t_op           r_op, n_op;
    logic [WW-1:0]           r_want, n_want;
    logic [DW-1:0]           r_cand, n_cand;
    logic [DW-1:0]           r_rem, n_rem;
    logic [DW-1:0]           r_base, n_base;
    logic [DW-1:0]           r_acc, n_acc;
    logic [BW-1:0]           r_bit, n_bit;
    logic [MW-1:0]           r_j, n_j;
    logic [MW-1:0]           r_widx, n_widx;
    logic [WW-1:0]           r_wcnt, n_wcnt;
    logic [CW-1:0]           r_count, n_count;
    logic                    r_trunc, n_trunc;
    logic [AW-1:0]           r_ridx, n_ridx;
    ccgs_pkg::t_status       r_status, n_status;

    logic                    accept;
    logic [LW:0]             len_diff;
    logic                    req_valid;
    logic [DW-1:0]           top, cand_lo, cand_hi;
    logic [DW-1:0]           tx_in, tx_out, sq_val;
    logic [WW-1:0]           weight_sum;
    logic                    ram_we;
    logic [DW-1:0]           ram_rdata;
    logic                    emit_last;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign len_diff  = {1'b0, i_block_length} - {1'b0, i_message_length};
    assign req_valid = (i_block_length != '0) && (i_message_length < i_block_length)
                       && (len_diff <= (LW+1)'(MAX_DEGREE));

    // Candidate range for degree m: odd polynomials with the top coefficient set.
    assign top     = DW'(1) << r_m;
    assign cand_lo = top | DW'(1);
    assign cand_hi = top | (top - DW'(1));

    // The one shared reduction step. While squaring it advances the accumulator and adds
    // in the base when the current coefficient of the base is set; otherwise it multiplies
    // the remainder by x.
    assign tx_in  = (r_state == S_MX) ? r_rem : r_acc;
    assign tx_out = f_times_x(tx_in, r_cand, top);
    assign sq_val = tx_out ^ (r_base[r_j] ? r_base : '0);

    assign weight_sum = r_wcnt + WW'(r_cand[r_widx]);
    assign emit_last  = (CW'(r_ridx) == (r_count - CW'(1)));

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_m      = r_m;
        n_op     = r_op;
        n_want   = r_want;
        n_cand   = r_cand;
        n_rem    = r_rem;
        n_base   = r_base;
        n_acc    = r_acc;
        n_bit    = r_bit;
        n_j      = r_j;
        n_widx   = r_widx;
        n_wcnt   = r_wcnt;
        n_count  = r_count;
        n_trunc  = r_trunc;
        n_ridx   = r_ridx;
        n_status = r_status;
        ram_we   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_n     = i_block_length;
                    n_op    = i_op;
                    n_want  = i_wanted_weight;
                    n_m     = len_diff[MW-1:0];
                    n_count = '0;
                    n_trunc = 1'b0;
                    if (req_valid) begin
                        n_state = S_TEST;
                    end else begin
                        n_status = ccgs_pkg::ST_INVALID;
                        n_state  = S_STAT;
                    end
                end
            end
            S_TEST: begin
                // The first pass through here sets up the starting candidate.
                if (r_count == '0 && r_cand == '0) begin
                    n_cand = (r_op == ccgs_pkg::OP_HIGHEST) ? cand_hi : cand_lo;
                end else if (r_op == ccgs_pkg::OP_WEIGHT) begin
                    n_widx  = '0;
                    n_wcnt  = '0;
                    n_state = S_WEIGHT;
                end else begin
                    n_state = S_POW;
                end
            end
            S_WEIGHT: begin
                n_wcnt = weight_sum;
                n_widx = r_widx + MW'(1);
                if (r_widx == r_m) begin
                    n_state = (weight_sum == r_want) ? S_POW : S_NEXT;
                end
            end
            S_POW: begin
                n_rem   = DW'(1);
                n_base  = DW'(1);
                n_acc   = '0;
                n_bit   = BW'(LW - 1);
                n_j     = r_m - MW'(1);
                n_state = S_SQ;
            end
            S_SQ: begin
                n_acc = sq_val;
                n_j   = r_j - MW'(1);
                if (r_j == '0) begin
                    n_rem = sq_val;
                    if (r_n[r_bit]) begin
                        n_state = S_MX;
                    end else if (r_bit == '0) begin
                        n_state = S_CHECK;
                    end else begin
                        n_bit  = r_bit - BW'(1);
                        n_base = sq_val;
                        n_acc  = '0;
                        n_j    = r_m - MW'(1);
                    end
                end
            end
            S_MX: begin
                n_rem = tx_out;
                if (r_bit == '0) begin
                    n_state = S_CHECK;
                end else begin
                    n_bit   = r_bit - BW'(1);
                    n_base  = tx_out;
                    n_acc   = '0;
                    n_j     = r_m - MW'(1);
                    n_state = S_SQ;
                end
            end
            S_CHECK: begin
                if (r_rem == DW'(1)) begin
                    if (r_count == CW'(MAX_RESULTS)) begin
                        n_trunc = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        ram_we  = 1'b1;
                        n_count = r_count + CW'(1);
                        if (r_op == ccgs_pkg::OP_LOWEST || r_op == ccgs_pkg::OP_HIGHEST) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_NEXT;
                        end
                    end
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_op == ccgs_pkg::OP_HIGHEST) begin
                    if (r_cand == cand_lo) begin
                        n_state = S_DONE;
                    end else begin
                        n_cand  = r_cand - DW'(2);
                        n_state = S_TEST;
                    end
                end else begin
                    if (r_cand == cand_hi) begin
                        n_state = S_DONE;
                    end else begin
                        n_cand  = r_cand + DW'(2);
                        n_state = S_TEST;
                    end
                end
            end
            S_DONE: begin
                n_cand = '0;
                n_ridx = '0;
                if (r_count == '0) begin
                    n_status = ccgs_pkg::ST_NONE;
                    n_state  = S_STAT;
                end else begin
                    n_status = ccgs_pkg::ST_FOUND;
                    n_state  = S_RD;
                end
            end
            S_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (emit_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_ridx  = r_ridx + AW'(1);
                    n_state = S_RD;
                end
            end
            S_STAT: begin
                n_cand  = '0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cand   <= '0;
            r_count  <= '0;
            r_trunc  <= 1'b0;
            r_ridx   <= '0;
            r_status <= ccgs_pkg::ST_FOUND;
        end else begin
            r_state  <= n_state;
            r_cand   <= n_cand;
            r_count  <= n_count;
            r_trunc  <= n_trunc;
            r_ridx   <= n_ridx;
            r_status <= n_status;
        end
    end

    // Working registers of the search carry no reset.
    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_m    <= n_m;
        r_op   <= n_op;
        r_want <= n_want;
        r_rem  <= n_rem;
        r_base <= n_base;
        r_acc  <= n_acc;
        r_bit  <= n_bit;
        r_j    <= n_j;
        r_widx <= n_widx;
        r_wcnt <= n_wcnt;
    end

    // Divisors are kept here until the search has ended, since the truncation flag on
    // every result and the last-result mark are only known then.
    ccgs_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_RESULTS),
        .AW    (AW)
    ) u_result_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_cand),
        .i_raddr (r_ridx),
        .o_rdata (ram_rdata)
    );

    assign o_result_valid = (r_state == S_EMIT) || (r_state == S_STAT);
    assign o_status       = r_status;
    assign o_generator    = (r_state == S_EMIT) ? ccgs_pkg::GEN_W'(ram_rdata) : '0;
    assign o_last_result  = (r_state == S_STAT) || ((r_state == S_EMIT) && emit_last);
    assign o_truncated    = (r_state == S_EMIT) && r_trunc;

    // A result only ever appears while the block is busy.
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result strobe outside a request");

    // A status-only result is always the last of its request.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != ccgs_pkg::ST_FOUND) |-> o_last_result)
        else $error("status result not marked last");

    // Truncation is only flagged on found divisors.
    a_trunc_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_truncated) |-> (o_status == ccgs_pkg::ST_FOUND))
        else $error("truncation flag on a status result");

    // An accepted request keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

endmodule
